@@ design/assert_macros.svh @@
// assert_macros.svh: concurrent assertion helpers for the compensation block
// clocked on clk_i and switched off while rst_ni is low; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_ALWAYS(lbl, !(cond), msg)
`endif

@@ design/bc_pkg.sv @@
// bc_pkg: shared types, constants and helpers of the barometer compensation block
// no dependencies; used by every module of the block except bc_dly
package bc_pkg;

  localparam int FRACTION_BITS_DEF = 24;
  localparam int RAW_W             = 24;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int MAC_LAT           = 6;
  localparam int OUT_LAT           = 4;
  localparam int DIV_EXTRA         = 2;

  localparam logic [RAW_W-1:0] SCALE_RESET = 24'd524288;

  typedef logic signed [63:0] fix_t;

  localparam fix_t FIX_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic ov;
    fix_t val;
  } sat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_TEMP_SCALE  = 3'd3,
    REG_PRESS_SCALE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pressure_out;
    logic signed [31:0] temperature_out;
    logic               overflow;
  } out_t;

  // saturate to the symmetric fixed-point range
  function automatic sat_t clamp_fix(fix_t v);
    sat_t r;
    r.ov  = 1'b0;
    r.val = v;
    if (v > FIX_LIM) begin
      r.ov  = 1'b1;
      r.val = FIX_LIM;
    end else if (v < -FIX_LIM) begin
      r.ov  = 1'b1;
      r.val = -FIX_LIM;
    end
    return r;
  endfunction

endpackage

@@ design/bc_div.sv @@
// bc_div: pipelined restoring divider, raw reading over scale register, one bit per stage
// depends on bc_pkg
module bc_div #(
  parameter int FRACTION_BITS = bc_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bc_pkg::RAW_W-1:0]   raw_i,
  input  logic [bc_pkg::RAW_W-1:0]   scale_i,
  output bc_pkg::fix_t               q_o
);

  localparam int NW = bc_pkg::RAW_W + FRACTION_BITS;

  logic [bc_pkg::RAW_W-1:0] k;
  logic [bc_pkg::RAW_W-1:0] u;
  logic [NW-1:0]            num;

  logic [bc_pkg::RAW_W-1:0] rem_q [NW+1];
  logic [NW-1:0]            nq_q  [NW+1];
  logic                     sgn_q [NW+1];

  logic [bc_pkg::RAW_W:0]   trial [NW];
  logic [bc_pkg::RAW_W:0]   diff  [NW];

  bc_pkg::fix_t             q_q;

  assign k   = (scale_i == '0) ? bc_pkg::RAW_W'(1) : scale_i;
  assign u   = raw_i[bc_pkg::RAW_W-1] ? (~raw_i + bc_pkg::RAW_W'(1)) : raw_i;
  assign num = {u, {FRACTION_BITS{1'b0}}} + NW'(k[bc_pkg::RAW_W-1:1]);

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      trial[i] = {rem_q[i], nq_q[i][NW-1]};
      diff[i]  = trial[i] - {1'b0, k};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      nq_q[0]  <= num;
      sgn_q[0] <= raw_i[bc_pkg::RAW_W-1];
      for (int i = 0; i < NW; i++) begin
        rem_q[i+1] <= diff[i][bc_pkg::RAW_W] ? trial[i][bc_pkg::RAW_W-1:0]
                                             : diff[i][bc_pkg::RAW_W-1:0];
        nq_q[i+1]  <= {nq_q[i][NW-2:0], ~diff[i][bc_pkg::RAW_W]};
        sgn_q[i+1] <= sgn_q[i];
      end
      q_q <= sgn_q[NW] ? -bc_pkg::fix_t'({{(64-NW){1'b0}}, nq_q[NW]})
                       :  bc_pkg::fix_t'({{(64-NW){1'b0}}, nq_q[NW]});
    end
  end

  assign q_o = q_q;

endmodule

@@ design/bc_mac.sv @@
// bc_mac: six-stage fixed-point multiply, round, saturate and saturating add
// depends on bc_pkg; the product is built from four 31 by 31 bit partial products
module bc_mac #(
  parameter int FRACTION_BITS = bc_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  bc_pkg::fix_t a_i,
  input  bc_pkg::fix_t b_i,
  input  bc_pkg::fix_t c_i,
  output bc_pkg::fix_t r_o,
  output logic         ov_o
);

  localparam int PW = 124;
  localparam logic [PW-1:0] RND = PW'(1) << (FRACTION_BITS - 1);

  bc_pkg::fix_t abs_a, abs_b, msgn, sum;
  bc_pkg::sat_t sat;

  logic         neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [61:0]  ma_q, mb_q;
  logic [61:0]  p00_q, p01_q, p10_q, p11_q;
  logic [62:0]  mid_q;
  logic [PW-1:0] hl_q, prod_q;
  logic [61:0]  m5_q;
  logic         ov5_q;
  bc_pkg::fix_t c1_q, c2_q, c3_q, c4_q, c5_q;
  bc_pkg::fix_t r_q;
  logic         ov_q;

  assign abs_a = a_i[63] ? -a_i : a_i;
  assign abs_b = b_i[63] ? -b_i : b_i;
  assign msgn  = neg5_q ? -bc_pkg::fix_t'({2'b00, m5_q}) : bc_pkg::fix_t'({2'b00, m5_q});
  assign sum   = c5_q + msgn;
  assign sat   = bc_pkg::clamp_fix(sum);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[63] ^ b_i[63];
      ma_q   <= abs_a[61:0];
      mb_q   <= abs_b[61:0];
      c1_q   <= c_i;

      neg2_q <= neg1_q;
      p00_q  <= 62'(ma_q[30:0]) * 62'(mb_q[30:0]);
      p01_q  <= 62'(ma_q[30:0]) * 62'(mb_q[61:31]);
      p10_q  <= 62'(ma_q[61:31]) * 62'(mb_q[30:0]);
      p11_q  <= 62'(ma_q[61:31]) * 62'(mb_q[61:31]);
      c2_q   <= c1_q;

      neg3_q <= neg2_q;
      mid_q  <= 63'(p01_q) + 63'(p10_q);
      hl_q   <= {p11_q, p00_q};
      c3_q   <= c2_q;

      neg4_q <= neg3_q;
      prod_q <= hl_q + (PW'(mid_q) << 31) + RND;
      c4_q   <= c3_q;

      neg5_q <= neg4_q;
      ov5_q  <= |prod_q[PW-1:FRACTION_BITS+62];
      m5_q   <= (|prod_q[PW-1:FRACTION_BITS+62]) ? {62{1'b1}}
                                                 : prod_q[FRACTION_BITS+61:FRACTION_BITS];
      c5_q   <= c4_q;

      r_q    <= sat.val;
      ov_q   <= ov5_q | sat.ov;
    end
  end

  assign r_o  = r_q;
  assign ov_o = ov_q;

endmodule

@@ design/bc_dly.sv @@
// bc_dly: stallable delay line that keeps live values level with the multiply stages
// no dependencies
module bc_dly #(
  parameter int W     = 64,
  parameter int DEPTH = 6
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

@@ design/bc_out.sv @@
// bc_out: final pressure sum, rounding to output fraction bits and 32-bit saturation
// depends on bc_pkg; four register stages, the last one is the output register
module bc_out #(
  parameter int FRACTION_BITS = bc_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  bc_pkg::fix_t p_i,
  input  bc_pkg::fix_t x_i,
  input  bc_pkg::fix_t t_i,
  input  logic         ov_i,
  output bc_pkg::out_t data_o
);

  localparam int SHIFT_P = FRACTION_BITS - 6;
  localparam int SHIFT_T = FRACTION_BITS - 16;
  localparam logic [62:0] HALF_P = (63'(1) << SHIFT_P) >> 1;
  localparam logic [62:0] HALF_T = (63'(1) << SHIFT_T) >> 1;

  function automatic logic [32:0] to_i32(logic neg, logic [62:0] u);
    logic [32:0] r;
    if (!neg && u > 63'h7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (neg && u > 63'h8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, neg ? (~u[31:0] + 32'd1) : u[31:0]};
    end
    return r;
  endfunction

  bc_pkg::sat_t sat;
  bc_pkg::fix_t abs_p, abs_t;
  logic [32:0]  cp, ct;

  bc_pkg::fix_t p1_q, t1_q;
  logic         ov1_q, ov2_q, ov3_q;
  logic         np2_q, nt2_q, np3_q, nt3_q;
  logic [61:0]  mp2_q, mt2_q;
  logic [62:0]  up3_q, ut3_q;
  bc_pkg::out_t data_q;

  assign sat   = bc_pkg::clamp_fix(p_i + x_i);
  assign abs_p = p1_q[63] ? -p1_q : p1_q;
  assign abs_t = t1_q[63] ? -t1_q : t1_q;
  assign cp    = to_i32(np3_q, up3_q);
  assign ct    = to_i32(nt3_q, ut3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= sat.val;
      t1_q  <= t_i;
      ov1_q <= ov_i | sat.ov;

      np2_q <= p1_q[63];
      nt2_q <= t1_q[63];
      mp2_q <= abs_p[61:0];
      mt2_q <= abs_t[61:0];
      ov2_q <= ov1_q;

      np3_q <= np2_q;
      nt3_q <= nt2_q;
      up3_q <= (63'(mp2_q) + HALF_P) >> SHIFT_P;
      ut3_q <= (63'(mt2_q) + HALF_T) >> SHIFT_T;
      ov3_q <= ov2_q;

      data_q.pressure_out    <= cp[31:0];
      data_q.temperature_out <= ct[31:0];
      data_q.overflow        <= ov3_q | cp[32] | ct[32];
    end
  end

  assign data_o = data_q;

endmodule

@@ design/barometer_compensation.sv @@
// Pressure and temperature compensation for a digital barometer.
// One input beat carries a raw 24-bit pressure and a raw 24-bit temperature,
// both two's complement; one output beat carries the compensated pressure
// (6 fraction bits), the compensated temperature (16 fraction bits) and an
// overflow flag set when any internal or output value was saturated.
// Both channels use valid/ready. Calibration words and scale factors are
// written through the cfg port (enable, index, data); the user must write
// them only while nothing is in flight, as the block does not enforce it.
// Throughput: one beat per cycle while the output is not stalled. The pipeline
// is made of the bit-per-stage scale dividers (26 + FRACTION_BITS stages),
// four levels of six-stage multiply-add units and four output rounding stages.
// Reset clears the pipeline valid bits, zeroes the calibration words and
// sets both scale factors to 524288; no clearing pass follows.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops until that result is taken.
// Depends on bc_pkg, bc_div, bc_mac, bc_dly, bc_out and assert_macros.svh.
`include "assert_macros.svh"
module barometer_compensation #(
  parameter int FRACTION_BITS = bc_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bc_pkg::in_t                     in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bc_pkg::out_t                    out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int DIV_LAT = bc_pkg::RAW_W + FRACTION_BITS + bc_pkg::DIV_EXTRA;
  localparam int LAT     = DIV_LAT + 4 * bc_pkg::MAC_LAT + bc_pkg::OUT_LAT;

  logic [23:0] cal_temp_q;
  logic [55:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [bc_pkg::RAW_W-1:0] temp_scale_q, press_scale_q;

  logic [LAT-1:0] vld_q;
  logic           pipe_en;

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;
  bc_pkg::fix_t c0h, c1f, c00f, c10f, c01f, c11f, c20f, c21f, c30f;

  bc_pkg::fix_t tsc, psc, psc1, tsc1, psc2, tsc2, tsc3;
  bc_pkg::fix_t i1, x1, t, i2, x2, t2, p1, x3, t3, p2, x34, t4;
  logic ov_i1, ov_x1, ov_t, ov_i2, ov_x2, ov_p1, ov_x3, ov_p2;
  logic ov_a2, ov_b3, ov_c4;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      temp_scale_q  <= bc_pkg::SCALE_RESET;
      press_scale_q <= bc_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (bc_pkg::cfg_reg_e'(cfg_idx_i))
        bc_pkg::REG_CAL_TEMP:    cal_temp_q    <= cfg_wdata_i[23:0];
        bc_pkg::REG_CAL_PRESS_A: cal_press_a_q <= cfg_wdata_i[55:0];
        bc_pkg::REG_CAL_PRESS_B: cal_press_b_q <= cfg_wdata_i;
        bc_pkg::REG_TEMP_SCALE:  temp_scale_q  <= cfg_wdata_i[bc_pkg::RAW_W-1:0];
        bc_pkg::REG_PRESS_SCALE: press_scale_q <= cfg_wdata_i[bc_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient unpacking
  assign c0  = cal_temp_q[23:12];
  assign c1  = cal_temp_q[11:0];
  assign c00 = cal_press_a_q[55:36];
  assign c10 = cal_press_a_q[35:16];
  assign c01 = cal_press_a_q[15:0];
  assign c11 = cal_press_b_q[63:48];
  assign c20 = cal_press_b_q[47:32];
  assign c21 = cal_press_b_q[31:16];
  assign c30 = cal_press_b_q[15:0];

  assign c0h  = bc_pkg::fix_t'(c0) <<< (FRACTION_BITS - 1);
  assign c1f  = bc_pkg::fix_t'(c1) <<< FRACTION_BITS;
  assign c00f = bc_pkg::fix_t'(c00) <<< FRACTION_BITS;
  assign c10f = bc_pkg::fix_t'(c10) <<< FRACTION_BITS;
  assign c01f = bc_pkg::fix_t'(c01) <<< FRACTION_BITS;
  assign c11f = bc_pkg::fix_t'(c11) <<< FRACTION_BITS;
  assign c20f = bc_pkg::fix_t'(c20) <<< FRACTION_BITS;
  assign c21f = bc_pkg::fix_t'(c21) <<< FRACTION_BITS;
  assign c30f = bc_pkg::fix_t'(c30) <<< FRACTION_BITS;

  // pipeline control
  assign pipe_en     = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // scaling
  bc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_t (
    .clk_i, .en_i(pipe_en), .raw_i(in_data_i.raw_temperature),
    .scale_i(temp_scale_q), .q_o(tsc)
  );
  bc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_p (
    .clk_i, .en_i(pipe_en), .raw_i(in_data_i.raw_pressure),
    .scale_i(press_scale_q), .q_o(psc)
  );

  // level 1
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_i1 (
    .clk_i, .en_i(pipe_en), .a_i(psc), .b_i(c30f), .c_i(c20f), .r_o(i1), .ov_o(ov_i1)
  );
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_x1 (
    .clk_i, .en_i(pipe_en), .a_i(psc), .b_i(c21f), .c_i(c11f), .r_o(x1), .ov_o(ov_x1)
  );
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_t (
    .clk_i, .en_i(pipe_en), .a_i(c1f), .b_i(tsc), .c_i(c0h), .r_o(t), .ov_o(ov_t)
  );
  bc_dly #(.W(128), .DEPTH(bc_pkg::MAC_LAT)) u_dly1 (
    .clk_i, .en_i(pipe_en), .d_i({psc, tsc}), .q_o({psc1, tsc1})
  );

  // level 2
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_i2 (
    .clk_i, .en_i(pipe_en), .a_i(psc1), .b_i(i1), .c_i(c10f), .r_o(i2), .ov_o(ov_i2)
  );
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_x2 (
    .clk_i, .en_i(pipe_en), .a_i(psc1), .b_i(x1), .c_i('0), .r_o(x2), .ov_o(ov_x2)
  );
  bc_dly #(.W(193), .DEPTH(bc_pkg::MAC_LAT)) u_dly2 (
    .clk_i, .en_i(pipe_en), .d_i({psc1, tsc1, t, ov_t | ov_i1 | ov_x1}),
    .q_o({psc2, tsc2, t2, ov_a2})
  );

  // level 3
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_p1 (
    .clk_i, .en_i(pipe_en), .a_i(psc2), .b_i(i2), .c_i(c00f), .r_o(p1), .ov_o(ov_p1)
  );
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_x3 (
    .clk_i, .en_i(pipe_en), .a_i(tsc2), .b_i(x2), .c_i('0), .r_o(x3), .ov_o(ov_x3)
  );
  bc_dly #(.W(129), .DEPTH(bc_pkg::MAC_LAT)) u_dly3 (
    .clk_i, .en_i(pipe_en), .d_i({tsc2, t2, ov_a2 | ov_i2 | ov_x2}),
    .q_o({tsc3, t3, ov_b3})
  );

  // level 4
  bc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac_p2 (
    .clk_i, .en_i(pipe_en), .a_i(tsc3), .b_i(c01f), .c_i(p1), .r_o(p2), .ov_o(ov_p2)
  );
  bc_dly #(.W(129), .DEPTH(bc_pkg::MAC_LAT)) u_dly4 (
    .clk_i, .en_i(pipe_en), .d_i({x3, t3, ov_b3 | ov_p1 | ov_x3}),
    .q_o({x34, t4, ov_c4})
  );

  // output rounding
  bc_out #(.FRACTION_BITS(FRACTION_BITS)) u_out (
    .clk_i, .en_i(pipe_en), .p_i(p2), .x_i(x34), .t_i(t4),
    .ov_i(ov_c4 | ov_p2), .data_o(out_data_o)
  );

  `ASSERT_ALWAYS(a_stall_holds_pipe, (out_valid_o && !out_ready_i) |=> $stable(vld_q),
                 "pipeline moved while the result beat was stalled")
  `ASSERT_ALWAYS(a_accept_enters, (in_valid_i && in_ready_o) |=> vld_q[0],
                 "accepted beat did not enter the pipeline")
  `ASSERT_ALWAYS(a_bubble_reaches_out, (in_ready_o && !vld_q[LAT-2]) |=> !out_valid_o,
                 "result beat appeared from an empty stage")
  `ASSERT_NEVER(a_stall_without_result, !in_ready_o && !out_valid_o,
                "input stalled with no result waiting")

endmodule
